@@ rtl/bba_pkg.sv @@
`default_nettype none

package bba_pkg;

    // Capacity and bitmap geometry
    localparam int MAX_BLOCKS  = 4096;
    localparam int WORD_BITS   = 64;
    localparam int NUM_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);

    // Field widths
    localparam int CMD_W       = 2;
    localparam int BLOCK_W     = 12;
    localparam int TOTAL_W     = 13;
    localparam int STATUS_W    = 2;

    // Priority encoder split: groups of eight bits
    localparam int GROUP_W     = 8;
    localparam int NUM_GROUPS  = WORD_BITS / GROUP_W;
    localparam int GROUP_IDX_W = $clog2(NUM_GROUPS);
    localparam int GROUP_BIT_W = $clog2(GROUP_W);

    // Configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int TOTAL_RESET = 4096;

    typedef enum logic [PADDR_W-3:0] {
        REG_TOTAL_BLOCKS = 1'b0
    } reg_idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_MARK  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    // Bitmap memory request from the sequencer
    typedef struct packed {
        logic [WORD_IDX_W-1:0] raddr;
        logic                  we;
        logic [WORD_IDX_W-1:0] waddr;
        logic [WORD_BITS-1:0]  wdata;
    } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/bba_if.sv @@
`default_nettype none

// Command channel
interface bba_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [bba_pkg::CMD_W-1:0]    cmd;
    logic [bba_pkg::BLOCK_W-1:0]  block_num;

    modport source (output valid, output cmd, output block_num, input ready);
    modport sink   (input valid, input cmd, input block_num, output ready);
endinterface

// Result channel
interface bba_res_if;
    logic                         valid;
    logic                         ready;
    logic [bba_pkg::STATUS_W-1:0] status;
    logic [bba_pkg::BLOCK_W-1:0]  result_block;

    modport source (output valid, output status, output result_block, input ready);
    modport sink   (input valid, input status, input result_block, output ready);
endinterface

`default_nettype wire

@@ rtl/bba_apb_regs.sv @@
`default_nettype none

module bba_apb_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bba_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [bba_pkg::PDATA_W-1:0]    pwdata,
    output logic      [bba_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready,
    output logic      [bba_pkg::TOTAL_W-1:0]    total_blocks
);

    logic [bba_pkg::TOTAL_W-1:0] total_reg;
    logic                        sel_total;
    logic                        wr_en;

    // Decode the word address
    assign sel_total = (paddr[bba_pkg::PADDR_W-1:2] == bba_pkg::REG_TOTAL_BLOCKS);
    assign wr_en     = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    // Hold the block count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= bba_pkg::TOTAL_W'(bba_pkg::TOTAL_RESET);
        end
        else if (wr_en && sel_total)
        begin
            total_reg <= pwdata[bba_pkg::TOTAL_W-1:0];
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (sel_total)
        begin
            prdata = bba_pkg::PDATA_W'(total_reg);
        end
    end

    assign total_blocks = total_reg;

endmodule

`default_nettype wire

@@ rtl/bba_bitmap_mem.sv @@
`default_nettype none

module bba_bitmap_mem (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bba_pkg::mem_req_t               req,
    output logic      [bba_pkg::WORD_BITS-1:0]   rdata
);

    logic [bba_pkg::WORD_BITS-1:0] mem [bba_pkg::NUM_WORDS];
    logic [bba_pkg::NUM_WORDS-1:0] written_reg;
    logic [bba_pkg::WORD_BITS-1:0] rdata_reg;
    logic                          rvalid_reg;

    // Storage array, no reset
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    // Track words written since reset; unwritten words read as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                written_reg[req.waddr] <= 1'b1;
            end
            rvalid_reg <= written_reg[req.raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

@@ rtl/bba_ffs.sv @@
`default_nettype none

module bba_ffs (
    input  wire logic [bba_pkg::WORD_BITS-1:0]  word,
    output logic                                found,
    output logic      [bba_pkg::BIT_IDX_W-1:0]  idx
);

    logic [bba_pkg::GROUP_IDX_W-1:0] grp;
    logic [bba_pkg::GROUP_BIT_W-1:0] sub;
    logic [bba_pkg::GROUP_W-1:0]     grp_bits;

    // Pick the lowest non-empty group
    always_comb
    begin
        grp   = '0;
        found = 1'b0;
        for (int i = bba_pkg::NUM_GROUPS - 1; i >= 0; i--)
        begin
            if (|word[i*bba_pkg::GROUP_W +: bba_pkg::GROUP_W])
            begin
                grp   = bba_pkg::GROUP_IDX_W'(i);
                found = 1'b1;
            end
        end
    end

    assign grp_bits = word[grp*bba_pkg::GROUP_W +: bba_pkg::GROUP_W];

    // Pick the lowest set bit within that group
    always_comb
    begin
        sub = '0;
        for (int j = bba_pkg::GROUP_W - 1; j >= 0; j--)
        begin
            if (grp_bits[j])
            begin
                sub = bba_pkg::GROUP_BIT_W'(j);
            end
        end
    end

    assign idx = {grp, sub};

endmodule

`default_nettype wire

@@ rtl/bba_seq.sv @@
`default_nettype none

module bba_seq (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [bba_pkg::TOTAL_W-1:0]       total_blocks,
    bba_cmd_if.sink                                in_ch,
    bba_res_if.source                              out_ch,
    output bba_pkg::mem_req_t                      mem_req,
    input  wire logic [bba_pkg::WORD_BITS-1:0]     rdata,
    output logic      [bba_pkg::WORD_BITS-1:0]     ffs_word,
    input  wire logic                              ffs_found,
    input  wire logic [bba_pkg::BIT_IDX_W-1:0]     ffs_idx
);

    localparam int WIW = bba_pkg::WORD_IDX_W;
    localparam int BIW = bba_pkg::BIT_IDX_W;
    localparam int WB  = bba_pkg::WORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD_RD,
        S_MOD_CHK,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [bba_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [bba_pkg::BLOCK_W-1:0]   blk_reg, blk_next;
    logic [WIW-1:0]                rd_idx_reg, rd_idx_next;
    logic [WIW-1:0]                chk_idx_reg, chk_idx_next;
    logic                          chk_pend_reg, chk_pend_next;
    bba_pkg::status_t              st_reg, st_next;
    logic [bba_pkg::BLOCK_W-1:0]   rblk_reg, rblk_next;
    logic                          res_valid_reg, res_valid_next;
    bba_pkg::status_t              res_status_reg, res_status_next;
    logic [bba_pkg::BLOCK_W-1:0]   res_block_reg, res_block_next;

    logic [bba_pkg::TOTAL_W-1:0]   lim;
    logic [bba_pkg::TOTAL_W-1:0]   lim_m1;
    logic [WIW-1:0]                last_word;
    logic [BIW-1:0]                last_bit;
    logic [WB-1:0]                 scan_mask;
    logic [WB-1:0]                 blk_onehot;
    logic [WB-1:0]                 ffs_onehot;
    logic                          in_range;
    logic                          blk_used;

    // Effective block count and the last word it reaches
    assign lim = (total_blocks > bba_pkg::TOTAL_W'(bba_pkg::MAX_BLOCKS))
               ? bba_pkg::TOTAL_W'(bba_pkg::MAX_BLOCKS) : total_blocks;
    assign lim_m1    = lim - bba_pkg::TOTAL_W'(1);
    assign last_word = lim_m1[BIW +: WIW];
    assign last_bit  = lim_m1[BIW-1:0];
    assign in_range  = ({1'b0, in_ch.block_num} < lim);

    // Keep only bits below the count in the last word
    assign scan_mask = (chk_idx_reg == last_word)
                     ? ({WB{1'b1}} >> (BIW'(WB - 1) - last_bit)) : {WB{1'b1}};
    assign ffs_word   = ~rdata & scan_mask;
    assign blk_onehot = WB'(1) << blk_reg[BIW-1:0];
    assign ffs_onehot = WB'(1) << ffs_idx;
    assign blk_used   = rdata[blk_reg[BIW-1:0]];

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = res_valid_reg;
    assign out_ch.status       = res_status_reg;
    assign out_ch.result_block = res_block_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        blk_next        = blk_reg;
        rd_idx_next     = rd_idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_pend_next   = chk_pend_reg;
        st_next         = st_reg;
        rblk_next       = rblk_reg;
        res_valid_next  = res_valid_reg & ~out_ch.ready;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;

        mem_req.raddr = blk_reg[BIW +: WIW];
        mem_req.we    = 1'b0;
        mem_req.waddr = blk_reg[BIW +: WIW];
        mem_req.wdata = rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    cmd_next  = in_ch.cmd;
                    blk_next  = in_ch.block_num;
                    rblk_next = '0;
                    if (in_ch.cmd == bba_pkg::CMD_ALLOC)
                    begin
                        rd_idx_next   = '0;
                        chk_pend_next = 1'b0;
                        if (lim == '0)
                        begin
                            st_next    = bba_pkg::ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if ((in_ch.cmd == bba_pkg::CMD_FREE ||
                              in_ch.cmd == bba_pkg::CMD_MARK) && in_range)
                    begin
                        state_next = S_MOD_RD;
                    end
                    else
                    begin
                        st_next    = bba_pkg::ST_RANGE;
                        state_next = S_DONE;
                    end
                end
            end

            S_MOD_RD:
            begin
                // Fetch the word holding the block
                state_next = S_MOD_CHK;
            end

            S_MOD_CHK:
            begin
                state_next = S_DONE;
                if (cmd_reg == bba_pkg::CMD_FREE && !blk_used)
                begin
                    st_next = bba_pkg::ST_DOUBLE;
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = (cmd_reg == bba_pkg::CMD_FREE)
                                  ? (rdata & ~blk_onehot) : (rdata | blk_onehot);
                    st_next       = bba_pkg::ST_OK;
                    rblk_next     = blk_reg;
                end
            end

            S_SCAN:
            begin
                // Issue the next word while checking the previous one
                mem_req.raddr = rd_idx_reg;
                mem_req.waddr = chk_idx_reg;
                rd_idx_next   = rd_idx_reg + WIW'(1);
                chk_idx_next  = rd_idx_reg;
                chk_pend_next = 1'b1;
                if (chk_pend_reg)
                begin
                    if (ffs_found)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = rdata | ffs_onehot;
                        st_next       = bba_pkg::ST_OK;
                        rblk_next     = bba_pkg::BLOCK_W'({chk_idx_reg, ffs_idx});
                        state_next    = S_DONE;
                    end
                    else if (chk_idx_reg == last_word)
                    begin
                        st_next    = bba_pkg::ST_FULL;
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                // Load the result once the output register is free
                if (!res_valid_reg || out_ch.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = st_reg;
                    res_block_next  = rblk_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            blk_reg        <= '0;
            rd_idx_reg     <= '0;
            chk_idx_reg    <= '0;
            chk_pend_reg   <= 1'b0;
            st_reg         <= bba_pkg::ST_OK;
            rblk_reg       <= '0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= bba_pkg::ST_OK;
            res_block_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            blk_reg        <= blk_next;
            rd_idx_reg     <= rd_idx_next;
            chk_idx_reg    <= chk_idx_next;
            chk_pend_reg   <= chk_pend_next;
            st_reg         <= st_next;
            rblk_reg       <= rblk_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_block_reg  <= res_block_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/block_bitmap_allocator.sv @@
`default_nettype none

// First-fit block allocator over a used/free bitmap of up to 4096 blocks.
//
// Commands arrive on in_ch (valid/ready): allocate, free or mark used, with
// a block number for the last two. Each item gives exactly one result on
// out_ch: a status and a block number (zero unless the status is ok).
// The block count is set through the APB register at byte address 0.
//
// Sequencing: free and mark pass through a read and a check state before the
// result is loaded; commands rejected at once go straight to loading it.
// Allocate walks the bitmap memory one 64-bit word per cycle through a single
// priority encoder, up to the word that holds the last block. One item is in
// work at a time; in_ch.ready is high only while the sequencer is idle.
//
// A result waits in an output register; the next item is still accepted
// while it waits, and a stalled receiver holds up the sequencer only when
// that next result is ready. Reset clears the whole bitmap at once (a
// per-word written flag makes unwritten words read as free) and sets the
// count to 4096.

module block_bitmap_allocator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bba_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [bba_pkg::PDATA_W-1:0]    pwdata,
    output logic      [bba_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready,
    bba_cmd_if.sink                             in_ch,
    bba_res_if.source                           out_ch
);

    logic [bba_pkg::TOTAL_W-1:0]   total_blocks;
    bba_pkg::mem_req_t             mem_req;
    logic [bba_pkg::WORD_BITS-1:0] rdata;
    logic [bba_pkg::WORD_BITS-1:0] ffs_word;
    logic                          ffs_found;
    logic [bba_pkg::BIT_IDX_W-1:0] ffs_idx;

    bba_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .total_blocks (total_blocks)
    );

    bba_bitmap_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (rdata)
    );

    bba_ffs u_ffs (
        .word  (ffs_word),
        .found (ffs_found),
        .idx   (ffs_idx)
    );

    bba_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .total_blocks (total_blocks),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .mem_req      (mem_req),
        .rdata        (rdata),
        .ffs_word     (ffs_word),
        .ffs_found    (ffs_found),
        .ffs_idx      (ffs_idx)
    );

    // A failed command never reports a block number
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != bba_pkg::ST_OK) |-> (out_ch.result_block == '0))
        else $error("non-zero block on failed command");

    // An accepted item keeps the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("ready while an item is in work");

    // The bitmap is written only while an item is in work
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> !in_ch.ready)
        else $error("bitmap write while idle");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none

module tb;
    import bba_pkg::*;

    // The command field can carry a code that no operation uses
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        status_t              status;
        logic [BLOCK_W-1:0]   blk;
    } block_reply_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    bba_cmd_if cmd_ch ();
    bba_res_if res_ch ();

    block_bitmap_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (cmd_ch),
        .out_ch  (res_ch)
    );

    // Predicted allocator state
    logic [MAX_BLOCKS-1:0] used_map;
    logic [TOTAL_W-1:0]    model_total;
    block_reply_t          predicted_replies[$];
    block_reply_t          want;

    int sender_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    int mismatches;
    int items_sent;
    int settings_used;
    int cycle_count;
    int status_seen[4];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_replies.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch on %s: got %0d, expected %0d (items sent %0d)",
                 what, got, exp_val, items_sent);
        mismatches++;
    endtask

    function automatic int effective_count();
        return (model_total > MAX_BLOCKS) ? MAX_BLOCKS : int'(model_total);
    endfunction

    // First-fit prediction: update the bitmap and work out the reply
    function automatic block_reply_t predict_reply(input logic [CMD_W-1:0] op,
                                                   input logic [BLOCK_W-1:0] blk);
        block_reply_t r;
        int           lim;
        int           b;
        logic         found;
        lim      = effective_count();
        r.status = ST_OK;
        r.blk    = '0;
        found    = 1'b0;
        case (op)
            CMD_ALLOC:
            begin
                r.status = ST_FULL;
                for (b = 0; b < lim && !found; b++)
                begin
                    if (!used_map[b])
                    begin
                        used_map[b] = 1'b1;
                        found       = 1'b1;
                        r.status    = ST_OK;
                        r.blk       = b[BLOCK_W-1:0];
                    end
                end
            end
            CMD_FREE:
            begin
                if (int'(blk) >= lim)
                    r.status = ST_RANGE;
                else if (!used_map[blk])
                    r.status = ST_DOUBLE;
                else
                begin
                    used_map[blk] = 1'b0;
                    r.blk         = blk;
                end
            end
            CMD_MARK:
            begin
                if (int'(blk) >= lim)
                    r.status = ST_RANGE;
                else
                begin
                    used_map[blk] = 1'b1;
                    r.blk         = blk;
                end
            end
            default:
                r.status = ST_RANGE;
        endcase
        return r;
    endfunction

    // Offer one item, with random idle cycles first; starts and ends at a falling edge
    task automatic issue_command(input logic [CMD_W-1:0] op, input logic [BLOCK_W-1:0] blk);
        while ($urandom_range(1, 100) <= sender_idle_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid     = 1'b1;
        cmd_ch.cmd       = op;
        cmd_ch.block_num = blk;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted_replies.push_back(predict_reply(op, blk));
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold until every predicted reply has come back
    task automatic wait_drained();
        cmd_ch.valid = 1'b0;
        while (predicted_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write the block count while idle, then read it back
    task automatic set_block_count(input logic [TOTAL_W-1:0] count);
        logic [PDATA_W-1:0] readback_want;
        wait_drained();
        readback_want                = '0;
        readback_want[TOTAL_W-1:0]   = count;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_TOTAL_BLOCKS, 2'b00};
        pwdata  = readback_want;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        model_total = count;
        settings_used++;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== readback_want)
            report_mismatch("block count readback", prdata, readback_want);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Favour blocks likely to be in use, with some anywhere and some at the edges
    function automatic logic [BLOCK_W-1:0] pick_block();
        int lim;
        int sel;
        lim = effective_count();
        sel = $urandom_range(0, 99);
        if (sel < 60 && lim > 0)
            return BLOCK_W'($urandom_range(0, ((lim > 96) ? 96 : lim) - 1));
        else if (sel < 85)
            return BLOCK_W'($urandom_range(0, MAX_BLOCKS - 1));
        else if (sel < 90)
            return (lim > 0) ? BLOCK_W'(lim - 1) : '0;
        else if (sel < 95)
            return (lim < MAX_BLOCKS) ? BLOCK_W'(lim) : '1;
        else
            return ($urandom_range(0, 1) == 0) ? '0 : '1;
    endfunction

    task automatic random_commands(input int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                issue_command(CMD_ALLOC, BLOCK_W'($urandom_range(0, MAX_BLOCKS - 1)));
            else if (sel < 70)
                issue_command(CMD_FREE, pick_block());
            else if (sel < 94)
                issue_command(CMD_MARK, pick_block());
            else
                issue_command(CMD_UNUSED, pick_block());
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input int count_a, input int count_b, input int n);
        set_block_count(TOTAL_W'(count_a));
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        random_commands(n);
        set_block_count(TOTAL_W'(count_b));
        random_commands(n);
    endtask

    // Block zero, edges of the block field, double free, re-mark, unused code, count extremes
    task automatic test_directed();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        issue_command(CMD_ALLOC, 12'h000);
        issue_command(CMD_ALLOC, 12'hFFF);
        issue_command(CMD_MARK, 12'hFFF);
        issue_command(CMD_ALLOC, 12'h000);
        issue_command(CMD_FREE, 12'hFFF);
        issue_command(CMD_FREE, 12'hFFF);
        issue_command(CMD_MARK, 12'h001);
        issue_command(CMD_FREE, 12'h000);
        issue_command(CMD_ALLOC, 12'h555);
        issue_command(CMD_UNUSED, 12'hFFF);
        issue_command(CMD_MARK, 12'hAAA);
        issue_command(CMD_FREE, 12'h555);
        issue_command(CMD_FREE, 12'hAAA);
        set_block_count(13'd0);
        issue_command(CMD_ALLOC, 12'h000);
        issue_command(CMD_FREE, 12'h000);
        issue_command(CMD_MARK, 12'h000);
        set_block_count(13'd1);
        issue_command(CMD_FREE, 12'h000);
        issue_command(CMD_ALLOC, 12'h000);
        issue_command(CMD_ALLOC, 12'h000);
        issue_command(CMD_MARK, 12'h001);
        set_block_count(13'h1FFF);
        issue_command(CMD_MARK, 12'hFFF);
        issue_command(CMD_FREE, 12'hFFF);
        set_block_count(13'd2);
        issue_command(CMD_ALLOC, 12'h000);
        issue_command(CMD_UNUSED, 12'h000);
    endtask

    task automatic test_random_mixes();
        run_phase(0, 0, 4096, 70, 45);
        run_phase(81, 0, 65, 8191, 45);
        run_phase(0, 81, 1, $urandom_range(2, 300), 45);
        run_phase(31, 31, 130, 5000, 45);
    endtask

    // Hold the receiver off for a long stretch while items keep coming
    task automatic test_backpressure();
        set_block_count(13'd200);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_request    = 300;
        random_commands(12);
    endtask

    // Stop sending until everything is back, then carry on
    task automatic test_pause_resume();
        sender_idle_pct = 31;
        recv_stall_pct  = 31;
        random_commands(8);
        wait_drained();
        random_commands(8);
    endtask

    // Receiver: random stalls, or a counted hold-off when requested
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            res_ch.ready = 1'b0;
            hold_left--;
        end
        else
            res_ch.ready = ($urandom_range(1, 100) > recv_stall_pct);
    end

    // Compare each accepted reply with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (predicted_replies.size() == 0)
                report_mismatch("unexpected reply status", res_ch.status, 0);
            else
            begin
                want = predicted_replies.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch("status", res_ch.status, want.status);
                if (res_ch.result_block !== want.blk)
                    report_mismatch("result_block", res_ch.result_block, want.blk);
                status_seen[want.status]++;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.cmd       = CMD_ALLOC;
        cmd_ch.block_num = '0;
        res_ch.ready     = 1'b0;
        used_map         = '0;
        model_total      = TOTAL_W'(TOTAL_RESET);
        sender_idle_pct  = 0;
        recv_stall_pct   = 0;
        hold_request     = 0;
        hold_left        = 0;
        mismatches       = 0;
        items_sent       = 0;
        settings_used    = 0;
        cycle_count      = 0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_mixes();
        test_backpressure();
        test_pause_resume();

        // Let any stray reply show up before closing
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d commands over %0d block-count settings", items_sent, settings_used);
        $display("replies: %0d ok, %0d out of blocks, %0d double free, %0d out of range",
                 status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_DOUBLE], status_seen[ST_RANGE]);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ block_bitmap_allocator.f @@
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_apb_regs.sv
rtl/bba_bitmap_mem.sv
rtl/bba_ffs.sv
rtl/bba_seq.sv
rtl/block_bitmap_allocator.sv
tb/sv/tb.sv
